[rtl/core/bvg_pkg.sv]
// ----------------------------------------------------------------------------
// bvg_pkg
// Shared widths, constants and register indexes for the battery voltage gauge.
// ----------------------------------------------------------------------------
`default_nettype none

package bvg_pkg;

    localparam int FRAC_BITS_DEF = 8;

    localparam int PIN_W      = 12;
    localparam int RATIO_W    = 16;
    localparam int CELLS_W    = 4;
    localparam int MV_W       = 16;
    localparam int PCT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int RATIO_SHIFT = 12;
    localparam int ALPHA_SHIFT = 16;
    localparam int SPAN_MV_W   = 14;

    localparam logic [15:0] ALPHA_KEEP = 16'd62259;
    localparam logic [15:0] ALPHA_NUM  = 16'd3277;
    localparam logic [15:0] RND_HALF   = 16'h8000;

    localparam logic [MV_W-1:0]      EMPTY_CELL_MV = 16'd3200;
    localparam logic [SPAN_MV_W-1:0] CELL_SPAN_MV  = 14'd1000;
    localparam logic [PCT_W-1:0]     PCT_FULL      = 7'd100;
    localparam logic [PCT_W-1:0]     PCT_EMPTY     = 7'd0;
    localparam logic [MV_W-1:0]      MV_MAX        = 16'hFFFF;

    localparam logic [MV_W-1:0]    AVG_RESET_MV      = 16'd12600;
    localparam logic [RATIO_W-1:0] RATIO_RESET       = 16'd16384;
    localparam logic [CELLS_W-1:0] CELLS_RESET       = 4'd3;
    localparam logic [MV_W-1:0]    LOW_THR_RESET     = 16'd10500;
    localparam logic [MV_W-1:0]    CRIT_THR_RESET    = 16'd9900;

    localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_RATIO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CRIT_THR      = 3'd3;

endpackage

`default_nettype wire

[rtl/core/bvg_pct_div.sv]
// ----------------------------------------------------------------------------
// bvg_pct_div
// Per-cell charge percent: range check, then a bit-serial restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module bvg_pct_div #(
    parameter int FRAC_BITS = bvg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [bvg_pkg::CELLS_W-1:0]   cells,
    input  wire logic [bvg_pkg::MV_W+FRAC_BITS-1:0] avg,
    output logic                               done,
    output logic [bvg_pkg::PCT_W-1:0]          pct
);

    localparam int AVG_W  = bvg_pkg::MV_W + FRAC_BITS;
    localparam int SPAN_W = bvg_pkg::SPAN_MV_W + FRAC_BITS;
    localparam int DSH_W  = SPAN_W + bvg_pkg::PCT_W - 1;
    localparam int REM_W  = SPAN_W + bvg_pkg::PCT_W;

    localparam logic [1:0] D_IDLE  = 2'd0;
    localparam logic [1:0] D_CHECK = 2'd1;
    localparam logic [1:0] D_SCALE = 2'd2;
    localparam logic [1:0] D_DIV   = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [AVG_W-1:0]             base_reg, base_next;
    logic [SPAN_W-1:0]            span_reg, span_next;
    logic [AVG_W-1:0]             diff_reg, diff_next;
    logic                         above_reg, above_next;
    logic [REM_W-1:0]             rem_reg, rem_next;
    logic [DSH_W-1:0]             dsh_reg, dsh_next;
    logic [bvg_pkg::PCT_W-1:0]    quot_reg, quot_next;
    logic [2:0]                   cnt_reg, cnt_next;
    logic                         done_reg, done_next;
    logic [bvg_pkg::PCT_W-1:0]    pct_reg, pct_next;

    logic [bvg_pkg::CELLS_W-1:0]   cells_eff;
    logic [bvg_pkg::MV_W-1:0]      base_mv;
    logic [bvg_pkg::SPAN_MV_W-1:0] span_mv;
    logic [REM_W-1:0]              diff_ext;
    logic [REM_W-1:0]              dsh_ext;
    logic                          fits;

    assign cells_eff = (cells == '0) ? bvg_pkg::CELLS_W'(1) : cells;
    assign base_mv   = bvg_pkg::MV_W'(cells_eff) * bvg_pkg::EMPTY_CELL_MV;
    assign span_mv   = bvg_pkg::SPAN_MV_W'(cells_eff) * bvg_pkg::CELL_SPAN_MV;
    assign diff_ext  = {{(REM_W-SPAN_W){1'b0}}, diff_reg[SPAN_W-1:0]};
    assign dsh_ext   = {1'b0, dsh_reg};
    assign fits      = rem_reg >= dsh_ext;

    always_comb begin
        state_next = state_reg;
        base_next  = base_reg;
        span_next  = span_reg;
        diff_next  = diff_reg;
        above_next = above_reg;
        rem_next   = rem_reg;
        dsh_next   = dsh_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        pct_next   = pct_reg;
        case (state_reg)
            D_IDLE: begin
                if (start) begin
                    base_next  = {base_mv, {FRAC_BITS{1'b0}}};
                    span_next  = {span_mv, {FRAC_BITS{1'b0}}};
                    state_next = D_CHECK;
                end
            end
            D_CHECK: begin
                above_next = avg > base_reg;
                diff_next  = avg - base_reg;
                state_next = D_SCALE;
            end
            D_SCALE: begin
                if (!above_reg) begin
                    pct_next   = bvg_pkg::PCT_EMPTY;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end else if (diff_reg >= {{(AVG_W-SPAN_W){1'b0}}, span_reg}) begin
                    pct_next   = bvg_pkg::PCT_FULL;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end else begin
                    // 100 * d = 64d + 32d + 4d
                    rem_next   = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);
                    dsh_next   = {span_reg, {(bvg_pkg::PCT_W-1){1'b0}}};
                    quot_next  = '0;
                    cnt_next   = 3'(bvg_pkg::PCT_W - 1);
                    state_next = D_DIV;
                end
            end
            D_DIV: begin
                if (fits) begin
                    rem_next = rem_reg - dsh_ext;
                end
                quot_next = {quot_reg[bvg_pkg::PCT_W-2:0], fits};
                dsh_next  = dsh_reg >> 1;
                cnt_next  = cnt_reg - 3'd1;
                if (cnt_reg == '0) begin
                    pct_next   = {quot_reg[bvg_pkg::PCT_W-2:0], fits};
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        base_reg  <= base_next;
        span_reg  <= span_next;
        diff_reg  <= diff_next;
        above_reg <= above_next;
        rem_reg   <= rem_next;
        dsh_reg   <= dsh_next;
        quot_reg  <= quot_next;
        cnt_reg   <= cnt_next;
        pct_reg   <= pct_next;
    end

    assign done = done_reg;
    assign pct  = pct_reg;

endmodule

`default_nettype wire

[rtl/core/battery_voltage_gauge_core.sv]
// ----------------------------------------------------------------------------
// battery_voltage_gauge_core
// Pack voltage EMA filter with per-cell charge percent and low/critical flags.
// Steps per input beat: bit-serial pin x ratio multiply, bit-serial EMA
// multiply-accumulate, round, the percent (range check, then a divide when in
// range), output load. One item in flight, so a new beat is taken only after
// the last one's result is loaded; the next beat is taken while a result waits.
// Reset (aresetn, synchronous, active low): average 12600 mV, registers to
// their default values, output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_voltage_gauge_core #(
    parameter int FRAC_BITS = bvg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bvg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bvg_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [bvg_pkg::PIN_W-1:0]         s_pin_mv,

    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [bvg_pkg::MV_W-1:0]               m_filtered_mv,
    output logic [bvg_pkg::PCT_W-1:0]              m_charge_percent,
    output logic                                   m_is_low,
    output logic                                   m_is_critical
);

    localparam int AVG_W  = bvg_pkg::MV_W + FRAC_BITS;
    localparam int PROD_W = bvg_pkg::PIN_W + bvg_pkg::RATIO_W;
    localparam int SH_W   = PROD_W + FRAC_BITS;
    localparam int EMA_W  = AVG_W + bvg_pkg::ALPHA_SHIFT + 1;
    localparam int RND_W  = EMA_W - bvg_pkg::ALPHA_SHIFT;

    localparam logic [AVG_W-1:0] AVG_CAP   = {bvg_pkg::MV_MAX, {FRAC_BITS{1'b0}}};
    localparam logic [AVG_W-1:0] AVG_RESET = {bvg_pkg::AVG_RESET_MV, {FRAC_BITS{1'b0}}};

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_EMA  = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [bvg_pkg::RATIO_W-1:0] divider_ratio_reg;
    logic [bvg_pkg::CELLS_W-1:0] cell_count_reg;
    logic [bvg_pkg::MV_W-1:0]    low_thr_reg;
    logic [bvg_pkg::MV_W-1:0]    crit_thr_reg;

    logic [2:0]                  state_reg, state_next;
    logic [3:0]                  cnt_reg, cnt_next;
    logic [bvg_pkg::PIN_W-1:0]   pin_sh_reg, pin_sh_next;
    logic [PROD_W-1:0]           mul_acc_reg, mul_acc_next;
    logic [EMA_W-1:0]            ema_acc_reg, ema_acc_next;
    logic [AVG_W-1:0]            avg_reg, avg_next;
    logic                        div_start_reg, div_start_next;

    logic                        m_valid_reg, m_valid_next;
    logic [bvg_pkg::MV_W-1:0]    m_filtered_reg, m_filtered_next;
    logic [bvg_pkg::PCT_W-1:0]   m_pct_reg, m_pct_next;
    logic                        m_low_reg, m_low_next;
    logic                        m_crit_reg, m_crit_next;

    logic [SH_W-1:0]             prod_sh;
    logic [AVG_W-1:0]            scaled;
    logic [EMA_W-1:0]            ema_round;
    logic [RND_W-1:0]            avg_new;
    logic [bvg_pkg::MV_W-1:0]    filtered;
    logic                        div_done;
    logic [bvg_pkg::PCT_W-1:0]   div_pct;
    logic                        out_free;

    assign prod_sh   = {mul_acc_reg, {FRAC_BITS{1'b0}}};
    assign scaled    = prod_sh[SH_W-1:bvg_pkg::RATIO_SHIFT];
    assign ema_round = ema_acc_reg + {{(EMA_W-16){1'b0}}, bvg_pkg::RND_HALF};
    assign avg_new   = ema_round[EMA_W-1:bvg_pkg::ALPHA_SHIFT];
    assign filtered  = avg_reg[AVG_W-1:FRAC_BITS];
    assign out_free  = !m_valid_reg || m_ready;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divider_ratio_reg <= bvg_pkg::RATIO_RESET;
            cell_count_reg    <= bvg_pkg::CELLS_RESET;
            low_thr_reg       <= bvg_pkg::LOW_THR_RESET;
            crit_thr_reg      <= bvg_pkg::CRIT_THR_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                bvg_pkg::REG_DIVIDER_RATIO: divider_ratio_reg <= cfg_data;
                bvg_pkg::REG_CELL_COUNT:    cell_count_reg    <= cfg_data[bvg_pkg::CELLS_W-1:0];
                bvg_pkg::REG_LOW_THR:       low_thr_reg       <= cfg_data;
                bvg_pkg::REG_CRIT_THR:      crit_thr_reg      <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pin_sh_next     = pin_sh_reg;
        mul_acc_next    = mul_acc_reg;
        ema_acc_next    = ema_acc_reg;
        avg_next        = avg_reg;
        div_start_next  = 1'b0;
        m_valid_next    = m_valid_reg && !m_ready;
        m_filtered_next = m_filtered_reg;
        m_pct_next      = m_pct_reg;
        m_low_next      = m_low_reg;
        m_crit_next     = m_crit_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pin_sh_next  = s_pin_mv;
                    mul_acc_next = '0;
                    cnt_next     = 4'(bvg_pkg::PIN_W - 1);
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                mul_acc_next = {mul_acc_reg[PROD_W-2:0], 1'b0}
                             + (pin_sh_reg[bvg_pkg::PIN_W-1]
                                ? {{bvg_pkg::PIN_W{1'b0}}, divider_ratio_reg} : '0);
                pin_sh_next  = {pin_sh_reg[bvg_pkg::PIN_W-2:0], 1'b0};
                cnt_next     = cnt_reg - 4'd1;
                if (cnt_reg == '0) begin
                    ema_acc_next = '0;
                    cnt_next     = 4'(bvg_pkg::ALPHA_SHIFT - 1);
                    state_next   = ST_EMA;
                end
            end
            ST_EMA: begin
                // MSB first over both alpha constants at once
                ema_acc_next = {ema_acc_reg[EMA_W-2:0], 1'b0}
                             + (bvg_pkg::ALPHA_KEEP[cnt_reg]
                                ? {{(EMA_W-AVG_W){1'b0}}, avg_reg} : '0)
                             + (bvg_pkg::ALPHA_NUM[cnt_reg]
                                ? {{(EMA_W-AVG_W){1'b0}}, scaled} : '0);
                cnt_next     = cnt_reg - 4'd1;
                if (cnt_reg == '0) begin
                    state_next = ST_RND;
                end
            end
            ST_RND: begin
                if (avg_new > {1'b0, AVG_CAP}) begin
                    avg_next = AVG_CAP;
                end else begin
                    avg_next = avg_new[AVG_W-1:0];
                end
                div_start_next = 1'b1;
                state_next     = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_filtered_next = filtered;
                    m_pct_next      = div_pct;
                    m_low_next      = filtered < low_thr_reg;
                    m_crit_next     = filtered < crit_thr_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            avg_reg       <= AVG_RESET;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            avg_reg       <= avg_next;
            div_start_reg <= div_start_next;
            m_valid_reg   <= m_valid_next;
        end
        cnt_reg        <= cnt_next;
        pin_sh_reg     <= pin_sh_next;
        mul_acc_reg    <= mul_acc_next;
        ema_acc_reg    <= ema_acc_next;
        m_filtered_reg <= m_filtered_next;
        m_pct_reg      <= m_pct_next;
        m_low_reg      <= m_low_next;
        m_crit_reg     <= m_crit_next;
    end

    bvg_pct_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pct_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .cells   (cell_count_reg),
        .avg     (avg_reg),
        .done    (div_done),
        .pct     (div_pct)
    );

    assign m_valid          = m_valid_reg;
    assign m_filtered_mv    = m_filtered_reg;
    assign m_charge_percent = m_pct_reg;
    assign m_is_low         = m_low_reg;
    assign m_is_critical    = m_crit_reg;

endmodule

`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for battery_voltage_gauge_core. A local predictor tracks
// the filtered pack voltage, charge percent and flags. Each pin beat that is
// sent queues one expected reading, and every result beat is compared with the
// oldest one. Directed tests cover register extremes, odd cell counts, small
// ratios and unused register indexes. Random traffic follows under three
// handshake profiles, with the registers set anew between chunks.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int FRAC  = bvg_pkg::FRAC_BITS_DEF;
    localparam int AVG_W = bvg_pkg::MV_W + FRAC;

    localparam logic [bvg_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd4;
    localparam logic [bvg_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    localparam int CHUNK_BEATS = 80;

    typedef struct packed {
        logic [bvg_pkg::MV_W-1:0]  filtered_mv;
        logic [bvg_pkg::PCT_W-1:0] charge_percent;
        logic                      is_low;
        logic                      is_critical;
    } gauge_reading_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [bvg_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bvg_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_valid;
    logic                           s_ready;
    logic [bvg_pkg::PIN_W-1:0]      s_pin_mv;
    logic                           m_valid;
    logic                           m_ready;
    logic [bvg_pkg::MV_W-1:0]       m_filtered_mv;
    logic [bvg_pkg::PCT_W-1:0]      m_charge_percent;
    logic                           m_is_low;
    logic                           m_is_critical;

    // predictor state and register copies
    logic [AVG_W-1:0]            avg_fx;
    logic [bvg_pkg::RATIO_W-1:0] ratio_q412;
    logic [bvg_pkg::CELLS_W-1:0] cell_count;
    logic [bvg_pkg::MV_W-1:0]    low_thr_mv;
    logic [bvg_pkg::MV_W-1:0]    crit_thr_mv;

    gauge_reading_t pending_readings[$];
    gauge_reading_t exp_reading;

    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    int unsigned pin_center;
    int          fail_count;
    int          beats_sent;
    int          results_seen;
    int          reg_writes;
    int          low_seen;
    int          crit_seen;
    int          partial_seen;

    battery_voltage_gauge_core #(
        .FRAC_BITS(FRAC)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pin_mv         (s_pin_mv),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_mv    (m_filtered_mv),
        .m_charge_percent (m_charge_percent),
        .m_is_low         (m_is_low),
        .m_is_critical    (m_is_critical)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic gauge_reading_t advance_gauge(input logic [bvg_pkg::PIN_W-1:0] pin);
        logic [63:0]    scaled;
        logic [63:0]    acc;
        logic [63:0]    cap;
        logic [63:0]    cells;
        logic [63:0]    base;
        logic [63:0]    span;
        logic [63:0]    pct;
        gauge_reading_t r;
        cap    = 64'(bvg_pkg::MV_MAX) << FRAC;
        scaled = ((64'(pin) * 64'(ratio_q412)) << FRAC) >> bvg_pkg::RATIO_SHIFT;
        acc    = (64'(avg_fx) * 64'(bvg_pkg::ALPHA_KEEP) + scaled * 64'(bvg_pkg::ALPHA_NUM)
                  + 64'(bvg_pkg::RND_HALF)) >> bvg_pkg::ALPHA_SHIFT;
        if (acc > cap) begin
            acc = cap;
        end
        avg_fx = acc[AVG_W-1:0];
        cells  = (cell_count == '0) ? 64'd1 : 64'(cell_count);
        base   = (64'(bvg_pkg::EMPTY_CELL_MV) * cells) << FRAC;
        span   = (64'(bvg_pkg::CELL_SPAN_MV) * cells) << FRAC;
        if (acc <= base) begin
            pct = 64'(bvg_pkg::PCT_EMPTY);
        end else begin
            pct = ((acc - base) * 64'd100) / span;
            if (pct > 64'(bvg_pkg::PCT_FULL)) begin
                pct = 64'(bvg_pkg::PCT_FULL);
            end
        end
        r.filtered_mv    = acc[FRAC +: bvg_pkg::MV_W];
        r.charge_percent = pct[bvg_pkg::PCT_W-1:0];
        r.is_low         = acc < (64'(low_thr_mv) << FRAC);
        r.is_critical    = acc < (64'(crit_thr_mv) << FRAC);
        return r;
    endfunction

    function automatic void apply_register(input logic [bvg_pkg::CFG_IDX_W-1:0] idx,
                                           input logic [bvg_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            bvg_pkg::REG_DIVIDER_RATIO: ratio_q412  = data;
            bvg_pkg::REG_CELL_COUNT:    cell_count  = data[bvg_pkg::CELLS_W-1:0];
            bvg_pkg::REG_LOW_THR:       low_thr_mv  = data;
            bvg_pkg::REG_CRIT_THR:      crit_thr_mv = data;
            default: ;
        endcase
    endfunction

    // holds the sender off until every queued reading has come back
    task automatic wait_results_drained;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(negedge aclk);
    endtask

    task automatic write_register(input logic [bvg_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [bvg_pkg::CFG_DATA_W-1:0] data);
        wait_results_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_register(idx, data);
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pin(input logic [bvg_pkg::PIN_W-1:0] pin);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        pending_readings.push_back(advance_gauge(pin));
        s_valid  <= 1'b1;
        s_pin_mv <= pin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                $error("result beat with nothing expected: filtered_mv %0d", m_filtered_mv);
                fail_count++;
            end else begin
                exp_reading = pending_readings.pop_front();
                results_seen++;
                if (m_filtered_mv !== exp_reading.filtered_mv) begin
                    $error("filtered_mv: expected %0d, got %0d",
                           exp_reading.filtered_mv, m_filtered_mv);
                    fail_count++;
                end
                if (m_charge_percent !== exp_reading.charge_percent) begin
                    $error("charge_percent: expected %0d, got %0d",
                           exp_reading.charge_percent, m_charge_percent);
                    fail_count++;
                end
                if (m_is_low !== exp_reading.is_low) begin
                    $error("is_low: expected %0d, got %0d", exp_reading.is_low, m_is_low);
                    fail_count++;
                end
                if (m_is_critical !== exp_reading.is_critical) begin
                    $error("is_critical: expected %0d, got %0d",
                           exp_reading.is_critical, m_is_critical);
                    fail_count++;
                end
                if (exp_reading.is_low) low_seen++;
                if (exp_reading.is_critical) crit_seen++;
                if (exp_reading.charge_percent != bvg_pkg::PCT_EMPTY &&
                    exp_reading.charge_percent != bvg_pkg::PCT_FULL) partial_seen++;
            end
        end
    end

    task automatic test_reset_defaults;
        send_pin(12'd0);
        send_pin(12'hFFF);
        send_pin(12'hAAA);
        send_pin(12'h555);
        send_pin(12'd3150);
    endtask

    task automatic test_divider_extremes;
        write_register(bvg_pkg::REG_DIVIDER_RATIO, 16'd4096);
        send_pin(12'hFFF);
        write_register(bvg_pkg::REG_DIVIDER_RATIO, 16'hFFFF);
        repeat (3) send_pin(12'hFFF);
        // ratios below 1.0
        write_register(bvg_pkg::REG_DIVIDER_RATIO, 16'd0);
        send_pin(12'd2048);
        write_register(bvg_pkg::REG_DIVIDER_RATIO, 16'd1000);
        send_pin(12'hFFF);
        write_register(bvg_pkg::REG_DIVIDER_RATIO, bvg_pkg::RATIO_RESET);
    endtask

    task automatic test_cell_count_cases;
        int counts [5];
        counts = '{0, 1, 8, 9, 15};
        for (int i = 0; i < 5; i++) begin
            write_register(bvg_pkg::REG_CELL_COUNT, 16'(counts[i]));
            send_pin(12'd3150);
        end
        write_register(bvg_pkg::REG_CELL_COUNT, 16'(bvg_pkg::CELLS_RESET));
    endtask

    task automatic test_threshold_extremes;
        write_register(bvg_pkg::REG_LOW_THR, 16'd0);
        write_register(bvg_pkg::REG_CRIT_THR, 16'd0);
        send_pin(12'd0);
        write_register(bvg_pkg::REG_LOW_THR, 16'hFFFF);
        write_register(bvg_pkg::REG_CRIT_THR, 16'hFFFF);
        send_pin(12'hFFF);
        write_register(bvg_pkg::REG_LOW_THR, bvg_pkg::LOW_THR_RESET);
        write_register(bvg_pkg::REG_CRIT_THR, bvg_pkg::CRIT_THR_RESET);
    endtask

    task automatic test_unknown_index;
        write_register(REG_UNUSED_LO, 16'hFFFF);
        write_register(REG_UNUSED_HI, 16'h0000);
        send_pin(12'd2000);
    endtask

    task automatic reconfigure_random;
        int unsigned mode;
        int unsigned cells;
        int unsigned ratio;
        int          target;
        int          low;
        int          crit;
        mode = $urandom_range(7);
        if (mode == 0) begin
            write_register(bvg_pkg::REG_DIVIDER_RATIO, 16'($urandom_range(0, 65535)));
            write_register(bvg_pkg::REG_CELL_COUNT, 16'($urandom_range(0, 65535)));
            write_register(bvg_pkg::REG_LOW_THR, 16'($urandom_range(0, 65535)));
            write_register(bvg_pkg::REG_CRIT_THR, 16'($urandom_range(0, 65535)));
            pin_center = $urandom_range(0, 4095);
        end else if (mode == 1) begin
            write_register(bvg_pkg::REG_DIVIDER_RATIO,
                           $urandom_range(1) ? 16'hFFFF : 16'd4096);
            write_register(bvg_pkg::REG_CELL_COUNT, $urandom_range(1) ? 16'd8 : 16'd1);
            write_register(bvg_pkg::REG_LOW_THR, $urandom_range(1) ? 16'hFFFF : 16'd0);
            write_register(bvg_pkg::REG_CRIT_THR, $urandom_range(1) ? 16'hFFFF : 16'd0);
            pin_center = $urandom_range(1) ? 4095 : 0;
        end else begin
            // pack level near the charge curve so percent and flags move
            cells  = $urandom_range(1, 8);
            ratio  = $urandom_range(4096, 65535);
            target = $urandom_range(3000 * cells, 4400 * cells);
            low    = target + int'($urandom_range(0, 1200)) - 600;
            crit   = low - int'($urandom_range(0, 800));
            if (crit < 0) crit = 0;
            write_register(bvg_pkg::REG_DIVIDER_RATIO, 16'(ratio));
            write_register(bvg_pkg::REG_CELL_COUNT, 16'(cells));
            write_register(bvg_pkg::REG_LOW_THR, 16'(low));
            write_register(bvg_pkg::REG_CRIT_THR, 16'(crit));
            pin_center = (target * 4096) / ratio;
            if (pin_center > 4095) pin_center = 4095;
        end
        if ($urandom_range(9) == 0) begin
            write_register(3'($urandom_range(4, 7)), 16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic test_random_traffic(input int unsigned src_pct,
                                       input int unsigned sink_pct,
                                       input int          n_beats);
        int pin;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        for (int i = 0; i < n_beats; i++) begin
            if (i % CHUNK_BEATS == 0) begin
                reconfigure_random();
            end
            if ($urandom_range(3) == 0) begin
                pin = $urandom_range(0, 4095);
            end else begin
                pin = int'(pin_center) + int'($urandom_range(0, 128)) - 64;
                if (pin < 0) pin = 0;
                if (pin > 4095) pin = 4095;
            end
            if ($urandom_range(149) == 0) begin
                wait_results_drained();
            end
            send_pin(12'(pin));
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        s_valid     = 1'b0;
        s_pin_mv    = '0;
        fail_count  = 0;
        beats_sent  = 0;
        results_seen = 0;
        reg_writes  = 0;
        low_seen    = 0;
        crit_seen   = 0;
        partial_seen = 0;
        pin_center  = 0;
        src_idle_pct  = 22;
        sink_idle_pct = 77;
        avg_fx      = AVG_W'(bvg_pkg::AVG_RESET_MV) << FRAC;
        ratio_q412  = bvg_pkg::RATIO_RESET;
        cell_count  = bvg_pkg::CELLS_RESET;
        low_thr_mv  = bvg_pkg::LOW_THR_RESET;
        crit_thr_mv = bvg_pkg::CRIT_THR_RESET;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_divider_extremes();
        test_cell_count_cases();
        test_threshold_extremes();
        test_unknown_index();
        test_random_traffic(22, 77, 640);
        test_random_traffic(77, 22, 640);
        test_random_traffic(0, 0, 640);

        wait_results_drained();
        repeat (64) @(posedge aclk);
        $display("Sent %0d pin beats and checked %0d results across %0d register writes",
                 beats_sent, results_seen, reg_writes);
        $display("Readings with low flag %0d, critical flag %0d, partial charge %0d",
                 low_seen, crit_seen, partial_seen);
        if (fail_count == 0 && pending_readings.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

[battery_voltage_gauge_core.f]
rtl/core/bvg_pkg.sv
rtl/core/bvg_pct_div.sv
rtl/core/battery_voltage_gauge_core.sv
bench/tb.sv
